>>> sv/zcid_pkg.sv
`timescale 1ns / 1ps
package zcid_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 20;
  localparam int FRAC_BITS   = 8;
  localparam int RATE_W      = 18;
  localparam int FREQ_W      = 32;
  localparam int EDGE_W      = INDEX_BITS + FRAC_BITS;
  localparam int DVD_W       = RATE_W + 2 * FRAC_BITS;
  localparam int REM_W       = EDGE_W;
  localparam int CNT_W       = $clog2(DVD_W + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(4000);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          record_start;
  } in_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_pos;
    logic              interval_valid;
    logic [FREQ_W-1:0] interval_freq;
    logic [EDGE_W-1:0] mid_pos;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem_init;
    logic [DVD_W-1:0] dvd;
    logic [REM_W-1:0] dvs;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> sv/zero_crossing_interval_detector_top.sv
`timescale 1ns / 1ps
// channel  | valid / ready          | payload
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_ready    | in_data  : sample, record_start
// out      | out_valid / out_ready  | out_data : edge_pos, interval_valid,
//          |                        |            interval_freq, mid_pos
// cfg      | cfg_valid / cfg_ready  | cfg_data : sample_rate
//
// a sample with no crossing leaves the block idle. a crossing runs one
// shared restoring divider: FRAC_BITS steps for the edge fraction, then,
// with a previous edge, 18 + 2*FRAC_BITS steps for the frequency. in_ready
// stays low until the result is loaded, which waits on out_ready in the
// emit state. reset is synchronous; sample_rate resets to 4000. a held
// result in the output register does not block the next transfer; only
// loading a new result waits on out_ready.
module zero_crossing_interval_detector_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  zcid_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output zcid_pkg::out_t       out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [17:0]          cfg_data
);
  import zcid_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FRAC = 2'd1;
  localparam logic [1:0] ST_FREQ = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                    state;
  logic [RATE_W-1:0]             sample_rate;
  logic signed [SAMPLE_BITS-1:0] last_sample;
  logic                          have_last_sample;
  logic [INDEX_BITS-1:0]         sample_index;
  logic [EDGE_W-1:0]             last_edge;
  logic                          have_edge;
  logic [INDEX_BITS-1:0]         cross_index;
  logic                          res_valid;
  logic [EDGE_W-1:0]             res_edge;
  logic [EDGE_W-1:0]             res_mid;
  logic [FREQ_W-1:0]             res_freq;

  logic                          in_xfer;
  logic                          crossing;
  logic signed [SAMPLE_BITS:0]   den;
  logic [EDGE_W-1:0]             edge_next;
  logic [EDGE_W-1:0]             edge_dist;
  logic [FREQ_W-1:0]             freq_sat;
  div_req_t                      req;
  div_rsp_t                      rsp;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // a record start clears the history, so that sample cannot end a crossing
  assign crossing = !in_data.record_start && have_last_sample &&
                    (last_sample > 0) && (in_data.sample < 0);
  assign den = {last_sample[SAMPLE_BITS-1], last_sample} -
               {in_data.sample[SAMPLE_BITS-1], in_data.sample};

  assign edge_next = {cross_index, rsp.quo[FRAC_BITS-1:0]};
  assign edge_dist = edge_next - last_edge;
  assign freq_sat  = (|rsp.quo[DVD_W-1:FREQ_W]) ? {FREQ_W{1'b1}} : rsp.quo[FREQ_W-1:0];

  always_comb begin
    req = '0;
    if (in_xfer && crossing) begin
      // remainder starts at prev: the integer part of prev/den is zero
      req.start    = 1'b1;
      req.rem_init = REM_W'(unsigned'(last_sample));
      req.dvs      = REM_W'(unsigned'(den));
      req.steps    = CNT_W'(FRAC_BITS);
    end else if (state == ST_FRAC && rsp.done && have_edge) begin
      req.start = 1'b1;
      req.dvd   = {sample_rate, {(2 * FRAC_BITS){1'b0}}};
      req.dvs   = edge_dist;
      req.steps = CNT_W'(DVD_W);
    end
  end

  zcid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      sample_rate      <= RATE_RESET;
      last_sample      <= '0;
      have_last_sample <= 1'b0;
      sample_index     <= '0;
      last_edge        <= '0;
      have_edge        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_rate <= cfg_data;
      end
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            last_sample      <= in_data.sample;
            have_last_sample <= 1'b1;
            if (in_data.record_start) begin
              sample_index <= INDEX_BITS'(1);
              have_edge    <= 1'b0;
              last_edge    <= '0;
            end else begin
              sample_index <= sample_index + INDEX_BITS'(1);
            end
            if (crossing) begin
              state <= ST_FRAC;
            end
          end
        end
        ST_FRAC: begin
          if (rsp.done) begin
            last_edge <= edge_next;
            have_edge <= 1'b1;
            state     <= have_edge ? ST_FREQ : ST_EMIT;
          end
        end
        ST_FREQ: begin
          if (rsp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cross_index <= sample_index;
    end
    if (state == ST_FRAC && rsp.done) begin
      res_edge  <= edge_next;
      res_valid <= have_edge;
      res_mid   <= have_edge ? (last_edge + {1'b0, edge_dist[EDGE_W-1:1]}) : '0;
    end
    if (state == ST_FREQ && rsp.done) begin
      res_freq <= freq_sat;
    end else if (state == ST_FRAC && rsp.done) begin
      res_freq <= '0;
    end
    if (state == ST_EMIT && (!out_valid || out_ready)) begin
      out_data.edge_pos       <= res_edge;
      out_data.interval_valid <= res_valid;
      out_data.interval_freq  <= res_freq;
      out_data.mid_pos        <= res_mid;
    end
  end

endmodule

>>> sv/zcid_div.sv
`timescale 1ns / 1ps
module zcid_div (
  input  logic                clk,
  input  logic                rst,
  input  zcid_pkg::div_req_t  req,
  output zcid_pkg::div_rsp_t  rsp
);
  import zcid_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;
  logic [REM_W-1:0] dvs;
  logic [DVD_W-1:0] dvd;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             qbit;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dvd;
      dvs <= req.dvs;
      cnt <= req.steps;
    end else if (busy) begin
      rem <= rem_next;
      // quotient bits fill in from the bottom as dividend bits leave the top
      dvd <= {dvd[DVD_W-2:0], qbit};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = dvd;

endmodule
